FILE: rtl/peb_pkg.sv
// shared constants, command codes and payload types for the pretrigger event builder
// no dependencies; imported by the interfaces and the top level
package peb_pkg;

  localparam int unsigned MAX_PRETRIGGER = 16;
  localparam int unsigned PT_W           = 5;
  localparam int unsigned CMD_W          = 2;
  localparam int unsigned ID_W           = 64;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [ID_W-1:0]  id_t;

  localparam cmd_t CMD_START = 2'd0;
  localparam cmd_t CMD_RUN   = 2'd1;
  localparam cmd_t CMD_STOP  = 2'd2;
  localparam cmd_t CMD_EXIT  = 2'd3;

endpackage

FILE: rtl/peb_in_if.sv
// input channel of the pretrigger event builder: valid/ready plus command payload
// depends on peb_pkg
interface peb_in_if;
  import peb_pkg::*;

  logic valid;
  logic ready;
  cmd_t cmd;
  id_t  record_id;
  logic trigger_in;

  modport source (output valid, output cmd, output record_id, output trigger_in,
                  input ready);
  modport sink   (input valid, input cmd, input record_id, input trigger_in,
                  output ready);
endinterface

FILE: rtl/peb_out_if.sv
// output channel of the pretrigger event builder: valid/ready plus result payload
// depends on peb_pkg
interface peb_out_if;
  import peb_pkg::*;

  logic valid;
  logic ready;
  cmd_t out_cmd;
  id_t  out_id;
  logic out_flag;
  logic last;

  modport source (output valid, output out_cmd, output out_id, output out_flag,
                  output last, input ready);
  modport sink   (input valid, input out_cmd, input out_id, input out_flag,
                  input last, output ready);
endinterface

FILE: rtl/peb_ram.sv
// generic simple dual-port ram, one write and one registered read port, read-first
// no dependencies
module peb_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pretrigger_event_builder.sv
// pretrigger event builder: history ids live in one ram, read-modify-write per item
// depends on peb_pkg, peb_in_if, peb_out_if and peb_ram
// buffering-only item: written at accept; single-result item: accept, then output load
// flush of n ids: n+1 beats, one per cycle unless stalled; input blocked until last beat
// rate is set by the single ram read port and the one-deep output register
// reset: passthrough mode, history empty, no clearing pass over the ram
module pretrigger_event_builder #(
  parameter int unsigned MaxPretrigger = peb_pkg::MAX_PRETRIGGER
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [peb_pkg::PT_W-1:0]  cfg_wdata_i,
  peb_in_if.sink                    in_i,
  peb_out_if.source                 out_o
);
  import peb_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPretrigger + 1);
  localparam int unsigned PtrW = (MaxPretrigger > 1) ? $clog2(MaxPretrigger) : 1;
  localparam int unsigned CmpW = (CntW > PT_W) ? CntW : PT_W;
  localparam int unsigned SumW = CntW + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FLUSH = 4'b0010,
    S_POP   = 4'b0100,
    S_FINAL = 4'b1000
  } state_e;

  typedef enum logic [4:0] {
    M_FILL    = 5'b00001,
    M_UNTRIG  = 5'b00010,
    M_NOPT    = 5'b00100,
    M_NEWTRIG = 5'b01000,
    M_TRIG    = 5'b10000
  } mode_e;

  function automatic logic [CntW-1:0] eff_depth(input logic [PT_W-1:0] p);
    logic [CmpW-1:0] p_ext;
    p_ext = CmpW'(p);
    if (p_ext > CmpW'(MaxPretrigger)) begin
      return CntW'(MaxPretrigger);
    end
    return CntW'(p);
  endfunction

  function automatic logic [PtrW-1:0] nxt_ptr(input logic [PtrW-1:0] p);
    if (p == PtrW'(MaxPretrigger - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  logic [PT_W-1:0]  pt_q, pt_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PtrW-1:0]  head_q, head_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  rem_q, rem_d;
  cmd_t             fin_cmd_q, fin_cmd_d;
  id_t              fin_id_q, fin_id_d;
  logic             fin_flag_q, fin_flag_d;
  logic             out_valid_q, out_valid_d;
  cmd_t             out_cmd_q, out_cmd_d;
  id_t              out_id_q, out_id_d;
  logic             out_flag_q, out_flag_d;
  logic             out_last_q, out_last_d;

  logic             ram_we, ram_re;
  logic [PtrW-1:0]  ram_waddr, ram_raddr;
  id_t              ram_rdata;

  logic [CntW-1:0]  pt_eff;
  logic [CntW-1:0]  cnt_inc;
  logic [SumW-1:0]  tail_sum;
  logic [PtrW-1:0]  tail;
  logic             accept;
  logic             out_free;
  logic             ld;
  cmd_t             ld_cmd;
  id_t              ld_id;
  logic             ld_flag;
  logic             ld_last;

  assign pt_eff   = eff_depth(pt_q);
  assign cnt_inc  = cnt_q + 1'b1;
  assign tail_sum = SumW'(head_q) + SumW'(cnt_q);
  assign tail     = (tail_sum >= SumW'(MaxPretrigger)) ?
                    PtrW'(tail_sum - SumW'(MaxPretrigger)) : PtrW'(tail_sum);
  assign accept   = in_i.valid && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    pt_d       = pt_q;
    cnt_d      = cnt_q;
    head_d     = head_q;
    rd_ptr_d   = rd_ptr_q;
    rem_d      = rem_q;
    fin_cmd_d  = fin_cmd_q;
    fin_id_d   = fin_id_q;
    fin_flag_d = fin_flag_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = tail;
    ram_raddr  = head_q;
    ld         = 1'b0;
    ld_cmd     = CMD_RUN;
    ld_id      = ram_rdata;
    ld_flag    = 1'b0;
    ld_last    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          fin_cmd_d  = in_i.cmd;
          fin_id_d   = '0;
          fin_flag_d = 1'b0;
          state_d    = S_FINAL;
          case (in_i.cmd)
            CMD_START: begin
              fin_cmd_d = CMD_START;
            end
            CMD_RUN: begin
              fin_id_d = in_i.record_id;
              if (mode_q inside {M_FILL, M_UNTRIG}) begin
                if (in_i.trigger_in) begin
                  fin_flag_d = 1'b1;
                  mode_d     = M_NEWTRIG;
                  if (cnt_q != '0) begin
                    // drain the history oldest first, then the triggering id
                    ram_re   = 1'b1;
                    rd_ptr_d = nxt_ptr(head_q);
                    rem_d    = cnt_q - 1'b1;
                    head_d   = tail;
                    cnt_d    = '0;
                    state_d  = S_FLUSH;
                  end
                end else if (mode_q == M_FILL) begin
                  ram_we  = 1'b1;
                  cnt_d   = cnt_inc;
                  state_d = S_IDLE;
                  if (cnt_inc >= pt_eff) begin
                    mode_d = M_UNTRIG;
                  end
                end else if (cnt_q == '0) begin
                  fin_flag_d = 1'b0;
                end else begin
                  // oldest leaves, new id takes the tail slot (read-first on a full ring)
                  ram_re  = 1'b1;
                  ram_we  = 1'b1;
                  head_d  = nxt_ptr(head_q);
                  state_d = S_POP;
                end
              end else if (mode_q == M_NOPT) begin
                fin_flag_d = in_i.trigger_in;
                if (in_i.trigger_in) begin
                  mode_d = M_NEWTRIG;
                end
              end else begin
                if (in_i.trigger_in) begin
                  fin_flag_d = 1'b1;
                  mode_d     = M_TRIG;
                end else if (pt_eff == '0) begin
                  mode_d = M_NOPT;
                end else begin
                  ram_we  = 1'b1;
                  cnt_d   = cnt_inc;
                  state_d = S_IDLE;
                  mode_d  = (pt_eff > CntW'(1)) ? M_FILL : M_UNTRIG;
                end
              end
            end
            default: begin
              mode_d = (pt_eff != '0) ? M_FILL : M_NOPT;
              head_d = '0;
              cnt_d  = '0;
              if (cnt_q != '0) begin
                ram_re   = 1'b1;
                rd_ptr_d = nxt_ptr(head_q);
                rem_d    = cnt_q - 1'b1;
                state_d  = S_FLUSH;
              end
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_flag = 1'b1;
          if (rem_q != '0) begin
            ram_re    = 1'b1;
            ram_raddr = rd_ptr_q;
            rd_ptr_d  = nxt_ptr(rd_ptr_q);
            rem_d     = rem_q - 1'b1;
          end else begin
            state_d = S_FINAL;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_cmd  = fin_cmd_q;
          ld_id   = fin_id_q;
          ld_flag = fin_flag_q;
          ld_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // register write restarts the history; write only while idle (not enforced)
    if (cfg_we_i) begin
      pt_d   = cfg_wdata_i;
      cnt_d  = '0;
      head_d = '0;
      mode_d = (eff_depth(cfg_wdata_i) != '0) ? M_FILL : M_NOPT;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_cmd_d   = out_cmd_q;
    out_id_d    = out_id_q;
    out_flag_d  = out_flag_q;
    out_last_d  = out_last_q;
    if (ld) begin
      out_valid_d = 1'b1;
      out_cmd_d   = ld_cmd;
      out_id_d    = ld_id;
      out_flag_d  = ld_flag;
      out_last_d  = ld_last;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_NOPT;
      pt_q        <= '0;
      cnt_q       <= '0;
      head_q      <= '0;
      rd_ptr_q    <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      pt_q        <= pt_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      rd_ptr_q    <= rd_ptr_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_cmd_q  <= fin_cmd_d;
    fin_id_q   <= fin_id_d;
    fin_flag_q <= fin_flag_d;
    out_cmd_q  <= out_cmd_d;
    out_id_q   <= out_id_d;
    out_flag_q <= out_flag_d;
    out_last_q <= out_last_d;
  end

  peb_ram #(
    .Width (ID_W),
    .Depth (MaxPretrigger)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.record_id),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.out_cmd  = out_cmd_q;
  assign out_o.out_id   = out_id_q;
  assign out_o.out_flag = out_flag_q;
  assign out_o.last     = out_last_q;

  // filling never reaches the configured depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_FILL) |-> (cnt_q < pt_eff))
    else $error("history count reached depth while filling");

  // history is empty whenever ids are not being buffered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_NOPT || mode_q == M_NEWTRIG || mode_q == M_TRIG) |-> (cnt_q == '0))
    else $error("history not empty outside buffering modes");

  // a flush empties the history at its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> (cnt_q == '0 && rem_q < CntW'(MaxPretrigger)))
    else $error("flush running with history still counted");

  // a pop only follows a full untriggered history
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (mode_q == M_UNTRIG && cnt_q != '0))
    else $error("pop outside untriggered mode");

endmodule
